>>> rtl/core/fwo_pkg.sv
package fwo_pkg;

    localparam int unsigned TabLen = 24;
    localparam int unsigned MaxStages = 24;
    localparam int unsigned DefStages = 14;

    localparam logic signed [63:0] KQ30 = 64'sd652032874;
    localparam logic signed [63:0] PiQ30 = 64'sd3373259426;
    localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;

    localparam logic [15:0] RstTickScale = 16'd16342;
    localparam logic [15:0] RstHalfLength = 16'd10240;
    localparam logic [15:0] RstHalfWidth = 16'd10240;
    localparam logic [13:0] RstCornerBearing = 14'd6434;

    localparam logic [1:0] RegTickScale = 2'd0;
    localparam logic [1:0] RegHalfLength = 2'd1;
    localparam logic [1:0] RegHalfWidth = 2'd2;
    localparam logic [1:0] RegCornerBearing = 2'd3;

    // Trig cell state: rotation mode carries x, y, residual angle.
    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;
    } t_rot;

    // Vectoring cell state: corner delta scaled by 2^16, with room for the CORDIC gain.
    typedef struct packed {
        logic signed [55:0] x;
        logic signed [55:0] y;
        logic signed [34:0] z;
    } t_vec;

    function automatic logic signed [31:0] atan_q30(input int unsigned i);
        logic signed [31:0] r;
        case (i)
            0: r = 32'h3243F6A8;  1: r = 32'h1DAC6705;  2: r = 32'h0FADBAFC;
            3: r = 32'h07F56EA6;  4: r = 32'h03FEAB76;  5: r = 32'h01FFD55B;
            6: r = 32'h00FFFAAA;  7: r = 32'h007FFF55;  8: r = 32'h003FFFEA;
            9: r = 32'h001FFFFD;  10: r = 32'h000FFFFF; 11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF; 13: r = 32'h0001FFFF; 14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF; 16: r = 32'h00003FFF; 17: r = 32'h00001FFF;
            18: r = 32'h00000FFF; 19: r = 32'h000007FF; 20: r = 32'h000003FF;
            21: r = 32'h000001FF; 22: r = 32'h000000FF; 23: r = 32'h0000007F;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/fwo_rot_cell.sv
module fwo_rot_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  fwo_pkg::t_rot i_d,
    output fwo_pkg::t_rot o_d
);
    import fwo_pkg::*;

    localparam logic signed [33:0] Atan = 34'(atan_q30(STAGE));

    t_rot n_d;
    t_rot r_d;

    always_comb begin
        n_d = i_d;
        if (!i_d.z[33]) begin
            n_d.x = i_d.x - (i_d.y >>> STAGE);
            n_d.y = i_d.y + (i_d.x >>> STAGE);
            n_d.z = i_d.z - Atan;
        end else begin
            n_d.x = i_d.x + (i_d.y >>> STAGE);
            n_d.y = i_d.y - (i_d.x >>> STAGE);
            n_d.z = i_d.z + Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> rtl/core/fwo_vec_cell.sv
module fwo_vec_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  fwo_pkg::t_vec i_d,
    output fwo_pkg::t_vec o_d
);
    import fwo_pkg::*;

    localparam logic signed [34:0] Atan = 35'(atan_q30(STAGE));

    t_vec n_d;
    t_vec r_d;

    always_comb begin
        n_d = i_d;
        if (!i_d.y[55]) begin
            n_d.x = i_d.x + (i_d.y >>> STAGE);
            n_d.y = i_d.y - (i_d.x >>> STAGE);
            n_d.z = i_d.z + Atan;
        end else begin
            n_d.x = i_d.x - (i_d.y >>> STAGE);
            n_d.y = i_d.y + (i_d.x >>> STAGE);
            n_d.z = i_d.z - Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> rtl/core/four_wheel_odometry_step_top.sv
// Channel | Signals                                   | Direction
// request | i_valid / o_ready + seven fields          | in
// result  | o_valid / i_ready + mean_x, mean_y, head   | out
// config  | i_cfg_valid / o_cfg_ready, index, data     | in
// One request enters every cycle while the output is not stalled; the path runs through the
// sine/cosine cell row followed by the atan2 cell row (stages capped at 24), plus the
// registers for setup, fold and travel, products, means, atan2 setup, bearing sum and the output.
// Reset clears the valid bits of the pipeline and the output register, and loads the
// register defaults. A stalled output holds the whole pipeline, so o_ready follows
// i_ready combinationally whenever the output register is full.
module four_wheel_odometry_step_top #(
    parameter int unsigned CORDIC_STAGES = fwo_pkg::DefStages
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_speed_front_left,
    input  logic signed [15:0] i_speed_rear_left,
    input  logic signed [15:0] i_speed_rear_right,
    input  logic signed [15:0] i_speed_front_right,
    input  logic        [15:0] i_elapsed_ms,
    input  logic signed [15:0] i_left_pod_angle,
    input  logic signed [15:0] i_right_pod_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_mean_x,
    output logic signed [31:0] o_mean_y,
    output logic signed [15:0] o_heading_change,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);
    import fwo_pkg::*;

    localparam int unsigned NStg = (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;
    // Stage plan: 0 rot input, 1..NStg rot cells, NStg+1 trig fold + travel,
    // NStg+2 rotate products, NStg+3 means, NStg+4 vec input, NStg+5..2NStg+4 vec cells,
    // 2NStg+5 bearing sum, 2NStg+6 output.
    localparam int unsigned Lat = 2 * NStg + 6;

    logic [15:0] r_tick_scale, r_half_length, r_half_width;
    logic [13:0] r_corner_bearing;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_scale <= RstTickScale;
            r_half_length <= RstHalfLength;
            r_half_width <= RstHalfWidth;
            r_corner_bearing <= RstCornerBearing;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegTickScale: r_tick_scale <= i_cfg_data;
                RegHalfLength: r_half_length <= i_cfg_data;
                RegHalfWidth: r_half_width <= i_cfg_data;
                RegCornerBearing: r_corner_bearing <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the output register is full and blocked.
    logic w_adv;
    logic r_ovalid;
    logic [Lat-1:0] r_vld;
    assign w_adv = !r_ovalid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
            r_ovalid <= r_vld[Lat-1];
        end
    end
    assign o_valid = r_ovalid;

    // ---------------- stage 0: travel product and trig setup
    logic signed [15:0] r0_spd [4];
    logic        [31:0] r0_tc;
    logic               r0_negl, r0_negr;
    t_rot               w_rl0, w_rr0, r_rl0, r_rr0;

    function automatic t_rot trig_init(input logic signed [15:0] a, output logic neg);
        logic signed [33:0] z;
        t_rot t;
        z = 34'(a) <<< 17;
        neg = 1'b0;
        if (z > 34'(HalfPiQ30)) begin
            z = z - 34'(PiQ30); neg = 1'b1;
        end else if (z < -34'(HalfPiQ30)) begin
            z = z + 34'(PiQ30); neg = 1'b1;
        end
        t.x = 36'(KQ30);
        t.y = '0;
        t.z = z;
        return t;
    endfunction

    logic w_nl, w_nr;
    always_comb begin
        w_rl0 = trig_init(i_left_pod_angle, w_nl);
        w_rr0 = trig_init(i_right_pod_angle, w_nr);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_spd[0] <= i_speed_front_left;
            r0_spd[1] <= i_speed_rear_left;
            r0_spd[2] <= i_speed_rear_right;
            r0_spd[3] <= i_speed_front_right;
            r0_tc <= i_elapsed_ms * r_tick_scale;
            r_rl0 <= w_rl0;
            r_rr0 <= w_rr0;
            r0_negl <= w_nl;
            r0_negr <= w_nr;
        end
    end

    // Rotation cell row; side data rides along in a matching shift line.
    t_rot w_rl [NStg+1];
    t_rot w_rr [NStg+1];
    assign w_rl[0] = r_rl0;
    assign w_rr[0] = r_rr0;

    typedef struct packed {
        logic signed [15:0] s0, s1, s2, s3;
        logic [31:0]        tc;
        logic               nl, nr;
    } t_side;
    t_side r_side [NStg+1];
    always_comb r_side[0] = '{r0_spd[0], r0_spd[1], r0_spd[2], r0_spd[3], r0_tc,
                              r0_negl, r0_negr};

    genvar g;
    generate
        for (g = 0; g < NStg; g++) begin : g_rot
            fwo_rot_cell #(.STAGE(g)) u_l (
                .i_clk(i_clk), .i_en(w_adv), .i_d(w_rl[g]), .o_d(w_rl[g+1])
            );
            fwo_rot_cell #(.STAGE(g)) u_r (
                .i_clk(i_clk), .i_en(w_adv), .i_d(w_rr[g]), .o_d(w_rr[g+1])
            );
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_side[g+1] <= r_side[g];
                end
            end
        end
    endgenerate

    // ---------------- stage A: fold sign, truncate to Q.15, travel
    logic signed [16:0] rA_cl, rA_sl, rA_cr, rA_sr;
    logic signed [35:0] rA_d [4];
    t_side w_sN;
    assign w_sN = r_side[NStg];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rA_cl <= 17'((w_sN.nl ? -w_rl[NStg].x : w_rl[NStg].x) >>> 15);
            rA_sl <= 17'((w_sN.nl ? -w_rl[NStg].y : w_rl[NStg].y) >>> 15);
            rA_cr <= 17'((w_sN.nr ? -w_rr[NStg].x : w_rr[NStg].x) >>> 15);
            rA_sr <= 17'((w_sN.nr ? -w_rr[NStg].y : w_rr[NStg].y) >>> 15);
            rA_d[0] <= 36'((49'(w_sN.s0) * $signed({1'b0, w_sN.tc})) >>> 12);
            rA_d[1] <= 36'((49'(w_sN.s1) * $signed({1'b0, w_sN.tc})) >>> 12);
            rA_d[2] <= 36'((49'(w_sN.s2) * $signed({1'b0, w_sN.tc})) >>> 12);
            rA_d[3] <= 36'((49'(w_sN.s3) * $signed({1'b0, w_sN.tc})) >>> 12);
        end
    end

    // ---------------- stage B: rotated travel plus corner
    logic signed [56:0] rB_px [4];
    logic signed [56:0] rB_py [4];
    logic signed [56:0] w_L, w_W;
    assign w_L = 57'($signed({1'b0, r_half_length})) <<< 8;
    assign w_W = 57'($signed({1'b0, r_half_width})) <<< 8;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rB_px[0] <= w_L + 57'((53'(rA_cl) * 53'(rA_d[0])) >>> 15);
            rB_py[0] <= w_W - 57'((53'(rA_sl) * 53'(rA_d[0])) >>> 15);
            rB_px[1] <= -w_L + 57'((53'(rA_cl) * 53'(rA_d[1])) >>> 15);
            rB_py[1] <= w_W + 57'((53'(rA_sl) * 53'(rA_d[1])) >>> 15);
            rB_px[2] <= -w_L + 57'((53'(rA_cr) * 53'(rA_d[2])) >>> 15);
            rB_py[2] <= -w_W + 57'((53'(rA_sr) * 53'(rA_d[2])) >>> 15);
            rB_px[3] <= w_L + 57'((53'(rA_cr) * 53'(rA_d[3])) >>> 15);
            rB_py[3] <= -w_W - 57'((53'(rA_sr) * 53'(rA_d[3])) >>> 15);
        end
    end

    // ---------------- stage C: means
    logic signed [56:0] rC_mx, rC_my;
    logic signed [56:0] rC_px [4];
    logic signed [56:0] rC_py [4];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rC_mx <= 57'((59'(rB_px[0]) + 59'(rB_px[1]) + 59'(rB_px[2]) + 59'(rB_px[3])) >>> 2);
            rC_my <= 57'((59'(rB_py[0]) + 59'(rB_py[1]) + 59'(rB_py[2]) + 59'(rB_py[3])) >>> 2);
            rC_px <= rB_px;
            rC_py <= rB_py;
        end
    end

    // ---------------- stage D: atan2 setup
    function automatic t_vec vec_init(input logic signed [56:0] dx,
                                      input logic signed [56:0] dy);
        t_vec v;
        logic signed [55:0] x, y;
        x = 56'(dx) <<< 16;
        y = 56'(dy) <<< 16;
        v.z = '0;
        if (x < 0) begin
            v.z = (y >= 0) ? 35'(PiQ30) : -35'(PiQ30);
            x = -x;
            y = -y;
        end
        v.x = x;
        v.y = y;
        return v;
    endfunction

    t_vec r_v0 [4];
    logic [3:0] rD_zero;
    logic signed [31:0] rD_mx, rD_my;
    typedef struct packed {
        logic [3:0]         zero;
        logic signed [31:0] mx;
        logic signed [31:0] my;
    } t_vside;
    t_vside r_vs [NStg+1];

    function automatic logic signed [31:0] sat32(input logic signed [56:0] v);
        if (v > 57'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -57'sd2147483648) return 32'sh80000000;
        return 32'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_v0[k] <= vec_init(rC_px[k] - rC_mx, rC_py[k] - rC_my);
                rD_zero[k] <= (rC_px[k] == rC_mx) && (rC_py[k] == rC_my);
            end
            rD_mx <= sat32(rC_mx);
            rD_my <= sat32(rC_my);
        end
    end
    always_comb r_vs[0] = '{rD_zero, rD_mx, rD_my};

    t_vec w_v [4][NStg+1];
    generate
        for (genvar w = 0; w < 4; w++) begin : g_wh
            assign w_v[w][0] = r_v0[w];
            for (g = 0; g < NStg; g++) begin : g_vec
                fwo_vec_cell #(.STAGE(g)) u_c (
                    .i_clk(i_clk), .i_en(w_adv), .i_d(w_v[w][g]), .o_d(w_v[w][g+1])
                );
            end
        end
        for (g = 0; g < NStg; g++) begin : g_vs
            always_ff @(posedge i_clk) begin
                if (w_adv) r_vs[g+1] <= r_vs[g];
            end
        end
    endgenerate

    // ---------------- stage E: bearing sum; corrections cancel except as written
    logic signed [37:0] rE_h;
    t_vside rE_s;
    logic signed [37:0] w_b [4];
    logic signed [37:0] w_cb;
    always_comb begin
        for (int k = 0; k < 4; k++)
            w_b[k] = r_vs[NStg].zero[k] ? 38'sd0 : 38'(w_v[k][NStg].z);
        w_cb = 38'($signed({1'b0, r_corner_bearing})) <<< 17;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rE_h <= w_b[0] - w_cb + w_b[1] - w_cb - 38'(HalfPiQ30)
                  + w_b[2] + w_cb + 38'(HalfPiQ30) + w_b[3] + w_cb;
            rE_s <= r_vs[NStg];
        end
    end

    // ---------------- stage F: output register
    logic signed [17:0] w_h;
    logic signed [15:0] w_hs;
    assign w_h = 18'(rE_h >>> 20);
    assign w_hs = (w_h > 18'sd32767) ? 16'sh7FFF :
                  (w_h < -18'sd32768) ? 16'sh8000 : 16'(w_h);

    logic signed [31:0] r_mx, r_my;
    logic signed [15:0] r_hc;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx <= rE_s.mx;
            r_my <= rE_s.my;
            r_hc <= w_hs;
        end
    end
    assign o_mean_x = r_mx;
    assign o_mean_y = r_my;
    assign o_heading_change = r_hc;
endmodule

>>> rtl/core/fwo_checker.sv
module fwo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_mean_x,
    input logic        o_cfg_ready
);
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mean_x))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");
    a_cfg: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("config port not ready");
endmodule

bind four_wheel_odometry_step_top fwo_checker u_fwo_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_mean_x(o_mean_x),
    .o_cfg_ready(o_cfg_ready)
);

>>> sim/four_wheel_odometry_step_top_tb.sv
module four_wheel_odometry_step_top_tb;
    import fwo_pkg::*;

    localparam int unsigned Stages = DefStages;
    localparam int unsigned Latency = 2 * Stages + 6;
    localparam int unsigned Quarter = 12868;   // pi/2 in Q2.13

    typedef struct {
        logic signed [15:0] spd [4];
        logic        [15:0] ms;
        logic signed [15:0] ang_l;
        logic signed [15:0] ang_r;
    } sample_t;

    typedef struct {
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [15:0] heading;
    } pose_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_speed_front_left = '0;
    logic signed [15:0] i_speed_rear_left = '0;
    logic signed [15:0] i_speed_rear_right = '0;
    logic signed [15:0] i_speed_front_right = '0;
    logic        [15:0] i_elapsed_ms = '0;
    logic signed [15:0] i_left_pod_angle = '0;
    logic signed [15:0] i_right_pod_angle = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_mean_x;
    logic signed [31:0] o_mean_y;
    logic signed [15:0] o_heading_change;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic        [1:0]  i_cfg_index = '0;
    logic        [15:0] i_cfg_data = '0;

    four_wheel_odometry_step_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    longint  cordic_atan [TabLen] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    logic [15:0] tick_scale = RstTickScale;
    logic [15:0] half_length = RstHalfLength;
    logic [15:0] half_width = RstHalfWidth;
    logic [13:0] corner_bearing = RstCornerBearing;

    sample_t pending_samples [$];
    pose_t   expected_poses [$];
    int      snd_idle_pct = 0;
    int      rcv_stall_pct = 0;
    logic    took = 1'b0;
    int      errors = 0;
    int      requests_sent = 0;
    int      poses_checked = 0;
    int      cfg_writes = 0;

    function automatic void pod_trig(input logic signed [15:0] ang,
                                     output longint c15, output longint s15);
        longint z, x, y, nx;
        bit     flip;
        z = longint'(ang) * 131072;
        x = KQ30;
        y = 0;
        flip = 1'b0;
        if (z > HalfPiQ30) begin
            z -= PiQ30;
            flip = 1'b1;
        end else if (z < -HalfPiQ30) begin
            z += PiQ30;
            flip = 1'b1;
        end
        for (int i = 0; i < Stages && i < TabLen; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= cordic_atan[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += cordic_atan[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c15 = x >>> 15;
        s15 = y >>> 15;
    endfunction

    function automatic longint corner_atan2(input longint yy, input longint xx);
        longint x, y, z, nx;
        if (xx == 0 && yy == 0) return 0;
        x = xx * 65536;
        y = yy * 65536;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PiQ30 : -PiQ30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < Stages && i < TabLen; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += cordic_atan[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= cordic_atan[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic pose_t predict_pose(input sample_t s);
        longint d [4];
        longint px [4];
        longint py [4];
        longint tc, len, wid, cl, sl, cr, sr, mx, my, cb, h;
        pose_t  r;
        tc = longint'(s.ms) * longint'(tick_scale);
        len = longint'(half_length) * 256;
        wid = longint'(half_width) * 256;
        for (int k = 0; k < 4; k++) d[k] = (longint'(s.spd[k]) * tc) >>> 12;
        pod_trig(s.ang_l, cl, sl);
        pod_trig(s.ang_r, cr, sr);
        px[0] = len + ((cl * d[0]) >>> 15);  py[0] = wid - ((sl * d[0]) >>> 15);
        px[1] = -len + ((cl * d[1]) >>> 15); py[1] = wid + ((sl * d[1]) >>> 15);
        px[2] = -len + ((cr * d[2]) >>> 15); py[2] = -wid + ((sr * d[2]) >>> 15);
        px[3] = len + ((cr * d[3]) >>> 15);  py[3] = -wid - ((sr * d[3]) >>> 15);
        mx = (px[0] + px[1] + px[2] + px[3]) >>> 2;
        my = (py[0] + py[1] + py[2] + py[3]) >>> 2;
        cb = longint'(corner_bearing) * 131072;
        // Each bearing is corrected to the front-left reference before averaging.
        h = corner_atan2(py[0] - my, px[0] - mx) - cb
          + corner_atan2(py[1] - my, px[1] - mx) - cb - HalfPiQ30
          + corner_atan2(py[2] - my, px[2] - mx) + cb + HalfPiQ30
          + corner_atan2(py[3] - my, px[3] - mx) + cb;
        h = h >>> 20;
        r.mean_x = 32'(clamp(mx, -64'sd2147483648, 64'sd2147483647));
        r.mean_y = 32'(clamp(my, -64'sd2147483648, 64'sd2147483647));
        r.heading = 16'(clamp(h, -64'sd32768, 64'sd32767));
        return r;
    endfunction

    // Request driver.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || took)) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                sample_t s;
                s = pending_samples.pop_front();
                i_valid <= 1'b1;
                i_speed_front_left <= s.spd[0];
                i_speed_rear_left <= s.spd[1];
                i_speed_rear_right <= s.spd[2];
                i_speed_front_right <= s.spd[3];
                i_elapsed_ms <= s.ms;
                i_left_pod_angle <= s.ang_l;
                i_right_pod_angle <= s.ang_r;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Request capture and result checking.
    always @(posedge i_clk) begin
        took <= i_valid && o_ready && i_rst_n;
        if (i_rst_n && i_valid && o_ready) begin
            sample_t s;
            s.spd[0] = i_speed_front_left;
            s.spd[1] = i_speed_rear_left;
            s.spd[2] = i_speed_rear_right;
            s.spd[3] = i_speed_front_right;
            s.ms = i_elapsed_ms;
            s.ang_l = i_left_pod_angle;
            s.ang_r = i_right_pod_angle;
            expected_poses.push_back(predict_pose(s));
            requests_sent++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d h=%0d", $time,
                         o_mean_x, o_mean_y, o_heading_change);
                errors++;
            end else begin
                pose_t e;
                e = expected_poses.pop_front();
                poses_checked++;
                if (o_mean_x !== e.mean_x) begin
                    $display("%0t: mean_x expected %0d actual %0d", $time, e.mean_x, o_mean_x);
                    errors++;
                end
                if (o_mean_y !== e.mean_y) begin
                    $display("%0t: mean_y expected %0d actual %0d", $time, e.mean_y, o_mean_y);
                    errors++;
                end
                if (o_heading_change !== e.heading) begin
                    $display("%0t: heading_change expected %0d actual %0d", $time,
                             e.heading, o_heading_change);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            RegTickScale: tick_scale = val;
            RegHalfLength: half_length = val;
            RegHalfWidth: half_width = val;
            RegCornerBearing: corner_bearing = val[13:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !i_valid && expected_poses.size() == 0);
        repeat (Latency + 10) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'(Quarter) : -16'(Quarter);
            2: return 16'($urandom_range(Quarter + 2, Quarter - 2));
            default: return 16'(int'($urandom_range(2 * 25736)) - 25736);
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        for (int k = 0; k < 4; k++) begin
            s.spd[k] = $urandom_range(3) == 0 ? 16'(int'($urandom_range(512)) - 256)
                                               : 16'($urandom);
        end
        s.ms = $urandom_range(3) == 0 ? 16'($urandom_range(50)) : 16'($urandom);
        s.ang_l = pick_angle();
        s.ang_r = pick_angle();
        return s;
    endfunction

    function automatic sample_t make_sample(input logic signed [15:0] v,
                                            input logic [15:0] ms,
                                            input logic signed [15:0] al,
                                            input logic signed [15:0] ar);
        sample_t s;
        for (int k = 0; k < 4; k++) s.spd[k] = (k % 2) ? -v : v;
        s.ms = ms;
        s.ang_l = al;
        s.ang_r = ar;
        return s;
    endfunction

    initial begin
        sample_t s;
        logic [15:0] cfg [4];
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, quarter-turn edges, angles past pi.
        pending_samples.push_back(make_sample(0, 0, 0, 0));
        pending_samples.push_back(make_sample(16'sh7FFF, 16'hFFFF, 0, 0));
        pending_samples.push_back(make_sample(-16'sh8000, 16'hFFFF, 0, 0));
        pending_samples.push_back(make_sample(16'sh7FFF, 16'hFFFF, 16'sd25736, -16'sd25736));
        pending_samples.push_back(make_sample(-16'sh8000, 16'hFFFF, -16'sd25736, 16'sd25736));
        pending_samples.push_back(make_sample(256, 1000, 16'(Quarter), -16'(Quarter)));
        pending_samples.push_back(make_sample(256, 1000, 16'(Quarter + 1), -16'(Quarter + 1)));
        pending_samples.push_back(make_sample(256, 1000, 16'sh7FFF, -16'sh8000));
        pending_samples.push_back(make_sample(-300, 500, 16'sd30000, -16'sd30000));
        pending_samples.push_back(make_sample(16'sh7FFF, 1, 16'sd6434, -16'sd6434));
        s = make_sample(0, 65535, 16'sd12000, -16'sd4000);
        s.spd[0] = 16'sh7FFF;
        s.spd[2] = -16'sh8000;
        pending_samples.push_back(s);
        s.spd[1] = 16'sh7FFF;
        s.spd[3] = 16'sh7FFF;
        pending_samples.push_back(s);
        for (int k = 0; k < 4; k++) s.spd[k] = 16'sh7FFF;
        s.ang_l = 0;
        s.ang_r = 0;
        pending_samples.push_back(s);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3FFF};
                2: cfg = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
                3: cfg = '{16'h0001, 16'h0010, 16'h0020, 16'(Quarter)};
                4: cfg = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
                default: cfg = '{16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom_range(16383))};
            endcase
            if (phase > 0)
                for (int r = 0; r < 4; r++) write_reg(2'(r), cfg[r]);
            case (phase % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 66; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 66; end
                default: begin snd_idle_pct = 29; rcv_stall_pct = 29; end
            endcase
            for (int n = 0; n < 117; n++) pending_samples.push_back(random_sample());
            // The sender holds off here until all results of the phase are back.
            drain();
        end

        $display("Sent %0d odometry requests over 8 register settings and 4 flow modes,",
                 requests_sent);
        $display("checked %0d poses, %0d register writes, %0d mismatches.",
                 poses_checked, cfg_writes, errors);
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("Timed out with %0d poses outstanding", expected_poses.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/fwo_pkg.sv
rtl/core/fwo_rot_cell.sv
rtl/core/fwo_vec_cell.sv
rtl/core/four_wheel_odometry_step_top.sv
rtl/core/fwo_checker.sv
sim/four_wheel_odometry_step_top_tb.sv
